### sv/block_xor_fold_unit_defines.svh
// assertion macros for the block xor fold unit
// used by the top level only; expects clk and rst in scope
`ifndef BLOCK_XOR_FOLD_UNIT_DEFINES_SVH
`define BLOCK_XOR_FOLD_UNIT_DEFINES_SVH

// clocked check, off while reset is high
`define BXF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define BXF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/bxf_pkg.sv
// shared constants and helpers for the block xor fold unit
// no dependencies
package bxf_pkg;

  localparam int BYTE_W     = 8;
  localparam int RESULT_W   = 64;
  localparam int LOG2_W     = 3;
  localparam int POS_W      = 3;
  localparam int BBYTES_W   = 4;
  localparam int SHIFT_W    = 6;

  localparam logic [LOG2_W-1:0] LOG2_NIBBLE = 3'd2;
  localparam logic [LOG2_W-1:0] LOG2_BYTE   = 3'd3;
  localparam logic [LOG2_W-1:0] LOG2_RESET  = 3'd3;

  // clamp the written block width code to the supported range
  function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] raw,
                                                 input logic [LOG2_W-1:0] max_log2);
    logic [LOG2_W-1:0] n;
    n = raw;
    if (n < LOG2_NIBBLE) begin
      n = LOG2_NIBBLE;
    end
    if (n > max_log2) begin
      n = max_log2;
    end
    return n;
  endfunction

endpackage

### sv/block_xor_fold_unit.sv
// block xor fold unit: top level with stream, config and output buffering
// depends on bxf_pkg and block_xor_fold_unit_defines.svh
//
// Usage:
//   s_* carries the byte stream (tdata = data_byte, tlast = last_byte).
//   Bytes are packed big-endian into blocks of 2^N bits and xor-folded.
//   m_* carries one 64-bit fold per stream, produced on the last byte.
//   cfg_* writes block_log2 (N, 2..6); each write also clears the stream
//   state, so writes belong between streams; cfg_ready is low while a byte is offered.
// Timing:
//   One byte is accepted per cycle while s_tready is high; the fold of a stream
//   goes to the result register (m_tvalid), or to the skid entry while a result is held. The byte pack,
//   xor and final pad shift all sit in one register-to-register pass.
// Stall:
//   A two-entry output buffer (result register plus skid) lets bytes keep
//   flowing while a result waits; s_tready drops only when both entries
//   hold results the receiver has not taken.
// Reset:
//   rst (synchronous, active high) sets N to 3, clears the fold state and
//   empties the output buffer.
module block_xor_fold_unit #(
  parameter int MAX_BLOCK_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,    // [2:0] block_log2
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] data_byte
  input  logic        s_tlast,     // last_byte
  // fold result out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata      // [63:0] fold_result
);

  localparam logic [bxf_pkg::LOG2_W-1:0] MaxLog2 =
    (MAX_BLOCK_BITS >= 64) ? 3'd6 :
    (MAX_BLOCK_BITS >= 32) ? 3'd5 :
    (MAX_BLOCK_BITS >= 16) ? 3'd4 : 3'd3;

  // configuration and fold state
  logic [bxf_pkg::LOG2_W-1:0]   block_log2;
  logic [bxf_pkg::RESULT_W-1:0] acc, acc_next;
  logic [MAX_BLOCK_BITS-1:0]    partial, partial_next;
  logic [bxf_pkg::POS_W-1:0]    pos, pos_next;

  // output buffer
  logic                         out_valid;
  logic [bxf_pkg::RESULT_W-1:0] out_data;
  logic                         skid_full;
  logic [bxf_pkg::RESULT_W-1:0] skid_data;

  logic                         cfg_write;
  logic                         item_fire;
  logic                         produce;
  logic                         out_free;
  logic [bxf_pkg::LOG2_W-1:0]   n_eff;
  logic [bxf_pkg::BBYTES_W-1:0] bytes_per_blk;
  logic [bxf_pkg::BBYTES_W-1:0] pos_inc;
  logic                         complete;
  logic [MAX_BLOCK_BITS-1:0]    shifted;
  logic [bxf_pkg::RESULT_W-1:0] shifted64;
  logic [bxf_pkg::POS_W-1:0]    pad_bytes;
  logic [bxf_pkg::SHIFT_W-1:0]  pad_shift;
  logic [bxf_pkg::RESULT_W-1:0] acc_step;
  logic [bxf_pkg::RESULT_W-1:0] fold;

  assign cfg_ready = !s_tvalid;
  assign cfg_write = cfg_valid && cfg_ready;
  assign s_tready  = !skid_full;
  assign item_fire = s_tvalid && s_tready && !cfg_write;
  assign produce   = item_fire && s_tlast;
  assign out_free  = !out_valid || m_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // block geometry from the width code
  always_comb begin
    n_eff         = bxf_pkg::eff_log2(block_log2, MaxLog2);
    bytes_per_blk = bxf_pkg::BBYTES_W'(1) << (n_eff - bxf_pkg::LOG2_BYTE);
    pos_inc       = {1'b0, pos} + bxf_pkg::BBYTES_W'(1);
    complete      = (pos_inc == bytes_per_blk);
    shifted       = MAX_BLOCK_BITS'({partial, s_tdata});
    shifted64     = bxf_pkg::RESULT_W'(shifted);
    pad_bytes     = bxf_pkg::POS_W'(bytes_per_blk - pos_inc);
    pad_shift     = {pad_bytes, 3'b000};
  end

  // per-byte pack and fold
  always_comb begin
    acc_step     = acc;
    partial_next = partial;
    pos_next     = pos;
    if (n_eff == bxf_pkg::LOG2_NIBBLE) begin
      acc_step = acc ^ bxf_pkg::RESULT_W'(s_tdata[7:4] ^ s_tdata[3:0]);
    end else if (complete) begin
      acc_step     = acc ^ shifted64;
      partial_next = '0;
      pos_next     = '0;
    end else begin
      partial_next = shifted;
      pos_next     = pos_inc[bxf_pkg::POS_W-1:0];
    end
    // final partial block is padded at its low end
    fold = acc_step;
    if (n_eff != bxf_pkg::LOG2_NIBBLE && !complete) begin
      fold = acc_step ^ (shifted64 << pad_shift);
    end
    acc_next = acc_step;
    if (s_tlast) begin
      acc_next     = '0;
      partial_next = '0;
      pos_next     = '0;
    end
  end

  // config register and fold state
  always_ff @(posedge clk) begin
    if (rst) begin
      block_log2 <= bxf_pkg::LOG2_RESET;
      acc        <= '0;
      partial    <= '0;
      pos        <= '0;
    end else if (cfg_write) begin
      block_log2 <= cfg_data;
      acc        <= '0;
      partial    <= '0;
      pos        <= '0;
    end else if (item_fire) begin
      acc        <= acc_next;
      partial    <= partial_next;
      pos        <= pos_next;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_free) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= produce;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_full <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_full) begin
        out_data <= skid_data;
        if (produce) begin
          skid_data <= fold;
        end
      end else if (produce) begin
        out_data <= fold;
      end
    end else if (produce) begin
      skid_data <= fold;
    end
  end

`include "block_xor_fold_unit_defines.svh"

  // a skid entry only exists behind a held result
  `BXF_ASSERT_ALWAYS(a_skid_behind_out, rst || !skid_full || out_valid, "skid full without result")
  // open block never reaches a whole block
  `BXF_ASSERT(a_pos_range, (n_eff == bxf_pkg::LOG2_NIBBLE) || ({1'b0, pos} < bytes_per_blk),
              "byte position past block end")
  // a config write starts a new stream
  `BXF_ASSERT(a_cfg_clears, cfg_write |=> (acc == '0) && (partial == '0) && (pos == '0),
              "config write did not clear fold state")

endmodule
